FILE: hw/rtl/wpgt_pkg.sv
`default_nettype none

package wpgt_pkg;

	// field widths
	localparam int SAMPLE_WIDTH = 16;
	localparam int LGAIN_W      = 7;
	localparam int WLEN_W       = 20;
	localparam int NUM_W        = 20;
	localparam int GAIN_W       = 24;
	localparam int CFG_W        = 20;
	localparam int CFG_IDX_W    = 3;

	// derived datapath widths
	localparam int SCALED_W  = SAMPLE_WIDTH + LGAIN_W;
	localparam int PEAK_W    = 2 * SCALED_W;
	localparam int FRAC_RAW  = (63 - PEAK_W) / 2;
	localparam int FRAC_BITS = (FRAC_RAW > 8) ? 8 : FRAC_RAW;
	localparam int RAD_W     = PEAK_W + 2 * FRAC_BITS;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int DVD_SHIFT = SAMPLE_WIDTH - 1 + FRAC_BITS;
	localparam int DVD_W     = NUM_W + DVD_SHIFT;
	localparam int STEP_W    = $clog2(DVD_W);
	localparam int PROD_W    = GAIN_W + 16;
	localparam int SUM_W     = PROD_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_NUM   = 3'd3;

	// register reset values
	localparam logic [LGAIN_W-1:0] LGAIN_RST = 7'd20;
	localparam logic [LGAIN_W-1:0] RGAIN_RST = 7'd20;
	localparam logic [WLEN_W-1:0]  WLEN_RST  = 20'd48000;
	localparam logic [NUM_W-1:0]   NUM_RST   = 20'd128502;

	// gain arithmetic, unsigned q8.16
	localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
	localparam logic [GAIN_W-1:0] GAIN_FLOOR = 24'd6554;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1310720;
	localparam logic [15:0]       W_AVG      = 16'd64881;
	localparam logic [15:0]       W_NEW      = 16'd655;
	localparam logic [15:0]       GAIN_ROUND = 16'd32768;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [SCALED_W-1:0] scaled_i;
		logic signed [SCALED_W-1:0] scaled_q;
		logic                       closes_window;
		logic [PEAK_W-1:0]          peak;
	} wpgt_item_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} wpgt_qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wpgt_queue.sv
`default_nettype none

module wpgt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wpgt_pkg::wpgt_item_t push_item,
	input  logic                 pop,
	output wpgt_pkg::wpgt_item_t head_item,
	output wpgt_pkg::wpgt_qstat_t stat
);
	import wpgt_pkg::*;

	wpgt_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_item     = slot_q[rd_ptr_q];
	assign stat.full     = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign stat.nonempty = (count_q != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/wpgt_front.sv
`default_nettype none

module wpgt_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sample_i,
	input  logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sample_q,
	input  logic [wpgt_pkg::LGAIN_W-1:0]           left_gain,
	input  logic [wpgt_pkg::LGAIN_W-1:0]           right_gain,
	input  logic [wpgt_pkg::WLEN_W-1:0]            window_length,
	input  wpgt_pkg::wpgt_qstat_t                  q_stat,
	output logic                                   push,
	output wpgt_pkg::wpgt_item_t                   push_item
);
	import wpgt_pkg::*;

	logic                       v_s1, v_s2;
	logic                       accept, adv_s2;
	logic signed [SCALED_W-1:0] prod_i, prod_q;
	logic signed [SCALED_W-1:0] vi_s1, vq_s1, vi_s2, vq_s2;
	logic signed [PEAK_W-1:0]   sq_i, sq_q;
	logic [PEAK_W-1:0]          sqi_s2, sqq_s2;
	logic [PEAK_W-1:0]          peak_q, mag_sq, peak_new;
	logic [WLEN_W-1:0]          count_q, count_new;
	logic                       closes;

	// stage 1: gain multiply
	assign prod_i = SCALED_W'(sample_i) * SCALED_W'($signed({1'b0, left_gain}));
	assign prod_q = SCALED_W'(sample_q) * SCALED_W'($signed({1'b0, right_gain}));

	// stage 2: squares
	assign sq_i = PEAK_W'(vi_s1) * PEAK_W'(vi_s1);
	assign sq_q = PEAK_W'(vq_s1) * PEAK_W'(vq_s1);

	// classify at the queue input: peak update and window end
	assign mag_sq    = sqi_s2 + sqq_s2;
	assign peak_new  = (mag_sq > peak_q) ? mag_sq : peak_q;
	assign count_new = count_q + 1'b1;
	assign closes    = (count_new >= window_length);

	assign push     = v_s2 && !q_stat.full;
	assign adv_s2   = v_s1 && (!v_s2 || push);
	assign in_ready = !v_s1 || !v_s2 || push;
	assign accept   = in_valid && in_ready;

	assign push_item.scaled_i      = vi_s2;
	assign push_item.scaled_q      = vq_s2;
	assign push_item.closes_window = closes;
	assign push_item.peak          = peak_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			peak_q  <= '0;
			count_q <= '0;
		end else begin
			v_s1 <= accept || (v_s1 && !adv_s2);
			v_s2 <= adv_s2 || (v_s2 && !push);
			if (push) begin
				peak_q  <= closes ? '0 : peak_new;
				count_q <= closes ? '0 : count_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vi_s1 <= prod_i;
			vq_s1 <= prod_q;
		end
		if (adv_s2) begin
			vi_s2  <= vi_s1;
			vq_s2  <= vq_s1;
			sqi_s2 <= $unsigned(sq_i);
			sqq_s2 <= $unsigned(sq_q);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/wpgt_back.sv
`default_nettype none

module wpgt_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wpgt_pkg::wpgt_item_t                  head_item,
	input  wpgt_pkg::wpgt_qstat_t                 q_stat,
	output logic                                  pop,
	input  logic [wpgt_pkg::NUM_W-1:0]            gain_numerator,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [wpgt_pkg::SCALED_W-1:0]  scaled_i,
	output logic signed [wpgt_pkg::SCALED_W-1:0]  scaled_q,
	output logic [wpgt_pkg::GAIN_W-1:0]           audio_gain,
	output logic                                  gain_updated
);
	import wpgt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQRT = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_SUM  = 6'b010000,
		ST_OUT  = 6'b100000
	} back_state_t;

	back_state_t                state_q;
	logic [STEP_W-1:0]          step_q;
	logic [RAD_W-1:0]           rad_q;
	logic [ROOT_W-1:0]          root_q;
	logic [ROOT_W:0]            srem_q;
	logic [DVD_W-1:0]           dvd_q;
	logic [ROOT_W-1:0]          drem_q;
	logic [GAIN_W-1:0]          gain_raw_q, gain_floored;
	logic [PROD_W-1:0]          prod_avg_q, prod_new_q;
	logic [GAIN_W-1:0]          cur_gain_q, avg_q;
	logic signed [SCALED_W-1:0] vi_q, vq_q;

	logic [ROOT_W+2:0] s_t, s_trial, s_diff;
	logic              s_ge;
	logic [ROOT_W:0]   d_t, d_diff;
	logic              d_ge;
	logic [DVD_W-1:0]  quot_next;
	logic [GAIN_W-1:0] quot_sat;
	logic [SUM_W-1:0]  gain_sum;
	logic [GAIN_W:0]   gain_shift;
	logic [GAIN_W-1:0] gain_new;

	logic out_free, pass_load, done_load, load;

	// square root, one result bit per cycle
	assign s_t     = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial = {1'b0, root_q, 2'b01};
	assign s_ge    = (s_t >= s_trial);
	assign s_diff  = s_t - s_trial;

	// restoring divide by the root, one quotient bit per cycle
	assign d_t       = {drem_q, dvd_q[DVD_W-1]};
	assign d_ge      = (d_t >= {1'b0, root_q});
	assign d_diff    = d_t - {1'b0, root_q};
	assign quot_next = {dvd_q[DVD_W-2:0], d_ge};
	assign quot_sat  = (|quot_next[DVD_W-1:GAIN_W]) ? GAIN_MAX : quot_next[GAIN_W-1:0];

	// floor and smoothing
	assign gain_floored = (gain_raw_q <= GAIN_FLOOR) ? GAIN_FLOOR : gain_raw_q;
	assign gain_sum     = SUM_W'(prod_avg_q) + SUM_W'(prod_new_q) + SUM_W'(GAIN_ROUND);
	assign gain_shift   = gain_sum[SUM_W-1:16];
	assign gain_new     = gain_shift[GAIN_W] ? GAIN_MAX : gain_shift[GAIN_W-1:0];

	assign out_free  = !out_valid || out_ready;
	assign pass_load = (state_q == ST_IDLE) && q_stat.nonempty &&
		!head_item.closes_window && out_free;
	assign done_load = (state_q == ST_OUT) && out_free;
	assign load      = pass_load || done_load;
	assign pop       = (state_q == ST_IDLE) && q_stat.nonempty &&
		(head_item.closes_window || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_valid  <= 1'b0;
			cur_gain_q <= GAIN_RESET;
			avg_q      <= '0;
		end else begin
			out_valid <= load || (out_valid && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (pop && head_item.closes_window) begin
						state_q <= (head_item.peak == '0) ? ST_MUL : ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					cur_gain_q <= gain_new;
					avg_q      <= gain_new;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop && head_item.closes_window) begin
					vi_q       <= head_item.scaled_i;
					vq_q       <= head_item.scaled_q;
					gain_raw_q <= cur_gain_q;
					rad_q      <= RAD_W'(head_item.peak) << (2 * FRAC_BITS);
					root_q     <= '0;
					srem_q     <= '0;
					step_q     <= STEP_W'(ROOT_W - 1);
				end
			end
			ST_SQRT: begin
				root_q <= {root_q[ROOT_W-2:0], s_ge};
				srem_q <= s_ge ? s_diff[ROOT_W:0] : s_t[ROOT_W:0];
				rad_q  <= rad_q << 2;
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					dvd_q  <= DVD_W'(gain_numerator) << DVD_SHIFT;
					drem_q <= '0;
					step_q <= STEP_W'(DVD_W - 1);
				end
			end
			ST_DIV: begin
				drem_q <= d_ge ? d_diff[ROOT_W-1:0] : d_t[ROOT_W-1:0];
				dvd_q  <= quot_next;
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					gain_raw_q <= quot_sat;
				end
			end
			ST_MUL: begin
				prod_avg_q <= PROD_W'(W_AVG) * PROD_W'(avg_q);
				prod_new_q <= PROD_W'(W_NEW) * PROD_W'(gain_floored);
			end
			default: begin
			end
		endcase

		if (pass_load) begin
			scaled_i     <= head_item.scaled_i;
			scaled_q     <= head_item.scaled_q;
			audio_gain   <= cur_gain_q;
			gain_updated <= 1'b0;
		end else if (done_load) begin
			scaled_i     <= vi_q;
			scaled_q     <= vq_q;
			audio_gain   <= cur_gain_q;
			gain_updated <= 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/windowed_peak_gain_tracker.sv
// channel   | direction | signals                                 | transfer
// ----------+-----------+-----------------------------------------+------------------------
// samples   | in        | in_valid, in_ready, sample_i, sample_q  | in_valid && in_ready
// results   | out       | out_valid, out_ready, scaled_i,         | out_valid && out_ready
//           |           |   scaled_q, audio_gain, gain_updated    |
// config    | in        | cfg_we, cfg_index, cfg_data             | cfg_we
//
// ordinary samples stream through stage 1, stage 2, the queue and the result register
// a sample that closes a window holds the result side while the bit-serial square root
//   and divider run, then through the multiply, sum and output states; a window whose
//   peak is zero skips the square root and divider
// the four-entry queue lets the input side keep taking samples meanwhile
// reset clears the pipeline, queue and window state; gain and registers get their defaults
// a stall on out_ready backs up through the queue to in_ready
`default_nettype none

module windowed_peak_gain_tracker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// sample input
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sample_i,
	input  logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sample_q,
	// result output
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [wpgt_pkg::SCALED_W-1:0]    scaled_i,
	output logic signed [wpgt_pkg::SCALED_W-1:0]    scaled_q,
	output logic [wpgt_pkg::GAIN_W-1:0]             audio_gain,
	output logic                                    gain_updated,
	// register writes
	input  logic                                    cfg_we,
	input  logic [wpgt_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [wpgt_pkg::CFG_W-1:0]              cfg_data
);
	import wpgt_pkg::*;

	// configuration registers: write only while the block is idle; the block does not enforce it
	logic [LGAIN_W-1:0] left_gain_q;
	logic [LGAIN_W-1:0] right_gain_q;
	logic [WLEN_W-1:0]  window_length_q;
	logic [NUM_W-1:0]   gain_numerator_q;

	// front to queue, queue to back
	logic        push, pop;
	wpgt_item_t  push_item, head_item;
	wpgt_qstat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_gain_q      <= LGAIN_RST;
			right_gain_q     <= RGAIN_RST;
			window_length_q  <= WLEN_RST;
			gain_numerator_q <= NUM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_GAIN:  left_gain_q      <= cfg_data[LGAIN_W-1:0];
				REG_RIGHT_GAIN: right_gain_q     <= cfg_data[LGAIN_W-1:0];
				REG_WINDOW_LEN: window_length_q  <= cfg_data[WLEN_W-1:0];
				REG_GAIN_NUM:   gain_numerator_q <= cfg_data[NUM_W-1:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// front: gain multiply, squared magnitude, peak and window tracking
	wpgt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_i      (sample_i),
		.sample_q      (sample_q),
		.left_gain     (left_gain_q),
		.right_gain    (right_gain_q),
		.window_length (window_length_q),
		.q_stat        (q_stat),
		.push          (push),
		.push_item     (push_item)
	);

	// classified samples wait here for the back end
	wpgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	// back: passes ordinary samples, runs the gain update on a window end
	wpgt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_item      (head_item),
		.q_stat         (q_stat),
		.pop            (pop),
		.gain_numerator (gain_numerator_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.scaled_i       (scaled_i),
		.scaled_q       (scaled_q),
		.audio_gain     (audio_gain),
		.gain_updated   (gain_updated)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/wpgt_checker.sv
`default_nettype none

module wpgt_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [wpgt_pkg::SCALED_W-1:0]    scaled_i,
	input logic signed [wpgt_pkg::SCALED_W-1:0]    scaled_q,
	input logic [wpgt_pkg::GAIN_W-1:0]             audio_gain,
	input logic                                    gain_updated
);
	import wpgt_pkg::*;

	// gain carried by the last result transfer
	logic [GAIN_W-1:0] last_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_gain_q <= GAIN_RESET;
		end else if (out_valid && out_ready) begin
			last_gain_q <= audio_gain;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(scaled_i) && $stable(scaled_q) &&
			$stable(audio_gain) && $stable(gain_updated))
		else $error("stalled result changed");

	a_gain_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !gain_updated |-> audio_gain == last_gain_q)
		else $error("gain changed without a window end");

endmodule

bind windowed_peak_gain_tracker wpgt_checker u_checker (.*);

`default_nettype wire

FILE: tb/sv/gain_tracker_checker.sv
`timescale 1ns / 100ps

module gain_tracker_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_ready,
	input  logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sample_i,
	input  logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sample_q,
	input  logic                                     out_valid,
	input  logic                                     out_ready,
	input  logic signed [wpgt_pkg::SCALED_W-1:0]     scaled_i,
	input  logic signed [wpgt_pkg::SCALED_W-1:0]     scaled_q,
	input  logic [wpgt_pkg::GAIN_W-1:0]              audio_gain,
	input  logic                                     gain_updated,
	input  logic                                     cfg_we,
	input  logic [wpgt_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [wpgt_pkg::CFG_W-1:0]               cfg_data,
	output int                                       errors,
	output int                                       results_due,
	output int                                       windows_closed
);

	localparam int          ROOT_FRAC  = 8;
	localparam logic [63:0] GAIN_TOP   = 64'd16777215;
	localparam logic [63:0] GAIN_FLOOR = 64'd6554;
	localparam logic [63:0] AVG_WEIGHT = 64'd64881;
	localparam logic [63:0] NEW_WEIGHT = 64'd655;
	localparam logic [63:0] ROUNDING   = 64'd32768;

	typedef struct packed {
		logic signed [wpgt_pkg::SCALED_W-1:0] scaled_i;
		logic signed [wpgt_pkg::SCALED_W-1:0] scaled_q;
		logic [wpgt_pkg::GAIN_W-1:0]          audio_gain;
		logic                                 gain_updated;
	} gain_result_t;

	gain_result_t pending_results[$];

	// register copies
	logic [6:0]  left_gain, right_gain;
	logic [19:0] window_len, gain_num;

	// window and gain state
	logic [63:0] peak_square;
	logic [19:0] window_count;
	logic [23:0] gain_now, gain_avg;

	function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
		logic [31:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = {32'd0, root | (32'd1 << b)};
			if (trial * trial <= x)
				root = trial[31:0];
		end
		return root;
	endfunction

	function automatic gain_result_t track_sample(
		input logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] si,
		input logic signed [wpgt_pkg::SAMPLE_WIDTH-1:0] sq
	);
		gain_result_t res;
		longint      vi, vq;
		logic [63:0] power, gain, dividend;
		logic [31:0] root;
		vi = longint'(si) * longint'({1'b0, left_gain});
		vq = longint'(sq) * longint'({1'b0, right_gain});
		power = vi * vi + vq * vq;
		res.gain_updated = 1'b0;
		if (power > peak_square)
			peak_square = power;
		window_count = window_count + 20'd1;
		if (window_count >= window_len) begin
			gain = {40'd0, gain_now};
			// an all-zero window takes the gain in use as its raw gain
			if (peak_square != 0) begin
				root = floor_sqrt(peak_square << (2 * ROOT_FRAC));
				dividend = {44'd0, gain_num} << (wpgt_pkg::SAMPLE_WIDTH - 1 + ROOT_FRAC);
				gain = dividend / {32'd0, root};
				if (gain > GAIN_TOP)
					gain = GAIN_TOP;
			end
			if (gain <= GAIN_FLOOR)
				gain = GAIN_FLOOR;
			gain = (AVG_WEIGHT * {40'd0, gain_avg} + NEW_WEIGHT * gain + ROUNDING) >> 16;
			if (gain > GAIN_TOP)
				gain = GAIN_TOP;
			gain_avg = gain[23:0];
			gain_now = gain[23:0];
			window_count = '0;
			peak_square = '0;
			res.gain_updated = 1'b1;
			windows_closed++;
		end
		res.scaled_i = vi[wpgt_pkg::SCALED_W-1:0];
		res.scaled_q = vq[wpgt_pkg::SCALED_W-1:0];
		res.audio_gain = gain_now;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gain_result_t want;
		if (!arst_n) begin
			left_gain = 7'd20;
			right_gain = 7'd20;
			window_len = 20'd48000;
			gain_num = 20'd128502;
			peak_square = '0;
			window_count = '0;
			gain_now = 24'd1310720;
			gain_avg = '0;
			pending_results.delete();
			errors = 0;
			windows_closed = 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wpgt_pkg::REG_LEFT_GAIN:  left_gain = cfg_data[6:0];
					wpgt_pkg::REG_RIGHT_GAIN: right_gain = cfg_data[6:0];
					wpgt_pkg::REG_WINDOW_LEN: window_len = cfg_data[19:0];
					wpgt_pkg::REG_GAIN_NUM:   gain_num = cfg_data[19:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_results.push_back(track_sample(sample_i, sample_q));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (scaled_i !== want.scaled_i) begin
						$error("scaled_i: expected %0d, got %0d", want.scaled_i, scaled_i);
						errors++;
					end
					if (scaled_q !== want.scaled_q) begin
						$error("scaled_q: expected %0d, got %0d", want.scaled_q, scaled_q);
						errors++;
					end
					if (audio_gain !== want.audio_gain) begin
						$error("audio_gain: expected %0d, got %0d", want.audio_gain, audio_gain);
						errors++;
					end
					if (gain_updated !== want.gain_updated) begin
						$error("gain_updated: expected %0d, got %0d",
							want.gain_updated, gain_updated);
						errors++;
					end
				end
			end
			results_due <= pending_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_windowed_peak_gain_tracker.sv
`timescale 1ns / 100ps

module tb_windowed_peak_gain_tracker;
	import wpgt_pkg::*;

	// cycles without any transfer before the run is called hung; the slowest
	// legal stretch is one window close plus a full receiver stall
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 86;
	// indexes above the last real register, all of them must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd4;
	localparam int UNUSED_REGS = 4;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_i;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           out_valid;
	logic                           out_ready;
	logic signed [SCALED_W-1:0]     scaled_i;
	logic signed [SCALED_W-1:0]     scaled_q;
	logic [GAIN_W-1:0]              audio_gain;
	logic                           gain_updated;
	logic                           cfg_we;
	logic [CFG_IDX_W-1:0]           cfg_index;
	logic [CFG_W-1:0]               cfg_data;

	int errors;
	int results_due;
	int windows_closed;
	int samples_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	// when set, that side runs back to back with no idle cycles
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	windowed_peak_gain_tracker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_i     (sample_i),
		.sample_q     (sample_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scaled_i     (scaled_i),
		.scaled_q     (scaled_q),
		.audio_gain   (audio_gain),
		.gain_updated (gain_updated),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	gain_tracker_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_i       (sample_i),
		.sample_q       (sample_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.scaled_i       (scaled_i),
		.scaled_q       (scaled_q),
		.audio_gain     (audio_gain),
		.gain_updated   (gain_updated),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.results_due    (results_due),
		.windows_closed (windows_closed)
	);

	// 10 ns clock
	always #5 clk = ~clk;

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAIL windowed_peak_gain_tracker");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall before each transfer, none when rx_steady
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one register write; the enable drops for a cycle so back-to-back writes
	// never lower and raise it in the same step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// full register set; gain writes carry junk above bit 6 that must be dropped
	task automatic configure(input logic [LGAIN_W-1:0] lg, input logic [LGAIN_W-1:0] rg,
			input logic [WLEN_W-1:0] wl, input logic [NUM_W-1:0] gn);
		write_reg(REG_LEFT_GAIN, {13'($urandom()), lg});
		write_reg(REG_RIGHT_GAIN, {13'($urandom()), rg});
		write_reg(REG_WINDOW_LEN, wl);
		write_reg(REG_GAIN_NUM, gn);
		settings_used++;
	endtask

	// sender holds off until every expected result is back, then lets the
	// pipeline settle before any register write
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// valid stays high across back-to-back transfers; it only drops for a gap
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] si,
			input logic signed [SAMPLE_WIDTH-1:0] sq);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_i <= si;
		sample_q <= sq;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
	endtask

	// mix of zero, full scale, small and fully random components
	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2, 3:    return SAMPLE_WIDTH'(int'($urandom_range(0, 510)) - 255);
			default: return SAMPLE_WIDTH'($urandom());
		endcase
	endfunction

	function automatic logic [LGAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			default: return LGAIN_W'($urandom_range(0, 127));
		endcase
	endfunction

	initial begin
		logic [WLEN_W-1:0] wl;
		logic [NUM_W-1:0]  gn;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_i = '0;
		sample_q = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: full-scale corners, long window so nothing closes yet
		rx_steady = 1'b0;
		send_sample(16'sh7fff, 16'sh8000);
		send_sample(16'sh8000, 16'sh7fff);
		send_sample('0, '0);
		send_sample(-16'sd1, 16'sd1);

		// window length zero acts as one: every sample recomputes the gain;
		// tiny peak saturates the raw gain, the zero pair hits the empty-peak path
		drain();
		configure('1, '1, '0, '1);
		send_sample(16'sd1, '0);
		send_sample(16'sh8000, 16'sh8000);
		send_sample('0, '0);

		// zero multiplier on I, zero numerator drives the raw gain to its floor
		drain();
		configure('0, 7'd5, 20'd1, '0);
		send_sample(16'sd12345, -16'sd12345);
		send_sample(16'sh7fff, 16'sh7fff);

		// writes above the last register must change nothing
		drain();
		for (int k = 0; k < UNUSED_REGS; k++)
			write_reg(REG_FIRST_UNUSED + CFG_IDX_W'(k), CFG_W'($urandom()));
		send_sample(-16'sd1, 16'sd1);

		// longest window, then cut it below the running count so the next
		// sample closes the window
		drain();
		configure('1, '1, '1, NUM_RST);
		tx_steady = 1'b1;
		for (int k = 0; k < 6; k++)
			send_sample(pick_sample(), pick_sample());
		drain();
		write_reg(REG_WINDOW_LEN, 20'd3);
		tx_steady = 1'b0;
		send_sample(16'sh8000, 16'sd7);
		send_sample(16'sd100, -16'sd100);

		// random phases, each with a fresh register set; the window count
		// carries over so shortened windows also occur here
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case ($urandom_range(0, 5))
				0:       wl = '0;
				1:       wl = 20'd1;
				2:       wl = WLEN_W'($urandom_range(25, 300));
				default: wl = WLEN_W'($urandom_range(2, 24));
			endcase
			case ($urandom_range(0, 5))
				0:       gn = '0;
				1:       gn = '1;
				2:       gn = NUM_RST;
				default: gn = NUM_W'($urandom());
			endcase
			configure(pick_gain(), pick_gain(), wl, gn);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, UNUSED_REGS - 1)),
					CFG_W'($urandom()));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// switch between stalled and back-to-back stretches
				if (n % 29 == 0) begin
					tx_steady = ($urandom_range(0, 3) == 0);
					rx_steady = ($urandom_range(0, 3) == 0);
				end
				if ($urandom_range(0, 11) == 0)
					send_sample('0, '0);
				else
					send_sample(pick_sample(), pick_sample());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d samples over %0d register sets, %0d windows closed",
			samples_sent, settings_used, windows_closed);
		$display("corners, zero/max window, unused registers and window cut were exercised");
		if (errors == 0 && results_due == 0)
			$display("PASS windowed_peak_gain_tracker");
		else
			$display("FAIL windowed_peak_gain_tracker");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/wpgt_pkg.sv
hw/rtl/wpgt_queue.sv
hw/rtl/wpgt_front.sv
hw/rtl/wpgt_back.sv
hw/rtl/windowed_peak_gain_tracker.sv
hw/rtl/wpgt_checker.sv
tb/sv/gain_tracker_checker.sv
tb/sv/tb_windowed_peak_gain_tracker.sv
